FILE: rtl/core/pba_pkg.sv
// Shared types and constants for the partition budget arbiter.
package pba_pkg;

	localparam int PART_W = 4;
	localparam int PRIO_W = 8;
	localparam int CYC_W = 32;
	localparam int FACT_W = 16;
	localparam int RFU_KEEP_BITS = 16;
	localparam int RFU_SHIFT = CYC_W - RFU_KEEP_BITS;

	localparam logic [1:0] MODE_UNDERLOAD = 2'd0;
	localparam logic [1:0] MODE_FREETIME = 2'd1;
	localparam logic [1:0] MODE_LIMIT = 2'd2;

	localparam logic REG_MIN_CYCLES = 1'b0;
	localparam logic REG_FREETIME_RATIO = 1'b1;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [CYC_W-1:0]  used;
		logic [CYC_W-1:0]  budget;
		logic [FACT_W-1:0] factor;
		logic [CYC_W-1:0]  offset;
		logic [CYC_W-1:0]  starve;
	} rec_t;

	typedef struct packed {
		logic [CYC_W-1:0]  starve;
		logic              run;
		logic [PRIO_W-1:0] prio;
		logic [CYC_W-1:0]  rfu;
		logic              crit;
		logic              may;
		logic [PART_W-1:0] part;
	} cand_t;

	typedef struct packed {
		logic  have;
		cand_t c;
	} best_t;

	typedef struct packed {
		logic init;
		logic valid;
		logic seed;
	} rank_ctl_t;

endpackage

FILE: rtl/core/pba_best.sv
// Running best-candidate tracker for one ranking rule.
module pba_best (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prio_en,
	input  pba_pkg::rank_ctl_t ctl,
	input  pba_pkg::cand_t     cand,
	output pba_pkg::best_t     best
);
	import pba_pkg::*;

	best_t best_q;
	logic  win;

	always_comb begin
		if (cand.starve < best_q.c.starve) begin
			win = 1'b0;
		end else if (cand.starve > best_q.c.starve || !best_q.have) begin
			win = 1'b1;
		end else if (cand.run != best_q.c.run) begin
			win = cand.run;
		end else if (prio_en && cand.prio != best_q.c.prio) begin
			win = cand.prio > best_q.c.prio;
		end else begin
			win = cand.rfu < best_q.c.rfu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctl.init) begin
			best_q <= '0;
		end else if (ctl.valid && (ctl.seed || win)) begin
			best_q.have <= 1'b1;
			best_q.c <= cand;
		end
	end

	assign best = best_q;

endmodule

FILE: rtl/core/partition_budget_arbiter_top.sv
// Top level of the partition budget arbiter: record store, decision walk, ports.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready | is_seed .. last_record, one record
// out     | output    | out_valid/out_ready | found .. sched_mode, one decision
// apb     | input     | psel/penable/pready | schedule margin, free-time ratio mode
//
// Records load one per cycle while in_ready is high, into a record memory with a
// registered read. A last_record transfer starts a walk: MAX_PARTS + 1 reads (seed,
// then each partition) through the read (margin check, rfu multiply) and rank stages,
// a flush until both stages are empty, then the result. in_ready is low from a
// last_record transfer through walk and flush, longer while the previous result waits.
// Reset clears loaded flags, seed flag and out_valid, not the memory or result data.
module partition_budget_arbiter_top #(
	parameter int MAX_PARTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          is_seed,
	input  logic [pba_pkg::PART_W-1:0]    part_id,
	input  logic [pba_pkg::PRIO_W-1:0]    top_prio,
	input  logic [pba_pkg::CYC_W-1:0]     spent_cycles,
	input  logic [pba_pkg::CYC_W-1:0]     budget_cycles,
	input  logic [pba_pkg::FACT_W-1:0]    rfu_factor,
	input  logic [pba_pkg::CYC_W-1:0]     rfu_offset,
	input  logic                          running_critical,
	input  logic                          holds_active,
	input  logic [pba_pkg::CYC_W-1:0]     starve_age,
	input  logic                          last_record,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [pba_pkg::PART_W-1:0]    chosen_part,
	output logic [pba_pkg::PRIO_W-1:0]    chosen_prio,
	output logic                          bill_critical,
	output logic [1:0]                    sched_mode,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import pba_pkg::*;

	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW = $clog2(MAX_PARTS + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [CW-1:0]        cnt_q;
	logic [CYC_W-1:0]     min_cycles_q;
	logic                 ratio_q;

	rec_t                 mem_q [MAX_PARTS];
	rec_t                 rd_q;
	logic [MAX_PARTS-1:0] loaded_q, crit_q, active_q;

	rec_t                 seed_rec_q;
	logic [PART_W-1:0]    seed_part_q;
	logic                 seed_crit_q, seed_valid_q;

	logic                 valid_s1, seed_s1;
	logic [IW-1:0]        idx_s1;

	logic                 valid_s2, seed_s2, may_s2, crit_s2, active_s2, zero_s2;
	logic [PRIO_W-1:0]    prio_s2;
	logic [CYC_W-1:0]     prod_s2, offset_s2, starve_s2;
	logic [IW-1:0]        idx_s2;

	logic [MAX_PARTS-1:0] comp_q;
	logic                 runable_any_q, sleep_any_q;

	logic                 out_valid_q, found_q, bill_q;
	logic [PART_W-1:0]    part_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [1:0]           mode_q;

	logic                 in_xfer, cfg_wr, wr_ok, out_free;
	logic [IW-1:0]        wr_addr, rd_addr;
	rec_t                 rec_s1;
	logic                 ld_s1, crit_s1, act_s1, may_s1;
	logic [CYC_W:0]       need_s1;
	logic [CYC_W-1:0]     prod_s1;
	cand_t                cand;
	rank_ctl_t            rctl;
	best_t                best_p, best_r, best;
	logic                 prio_en, run_s2;
	logic [MAX_PARTS-1:0] comp_x;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_FREETIME_RATIO) ? {31'b0, ratio_q} : min_cycles_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cycles_q <= '0;
			ratio_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MIN_CYCLES: min_cycles_q <= pwdata;
				REG_FREETIME_RATIO: ratio_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_LOAD);
	assign in_xfer = in_valid && in_ready;
	assign wr_addr = IW'(part_id);
	assign wr_ok = in_xfer && !is_seed &&
		({{(32-PART_W){1'b0}}, part_id} < 32'(MAX_PARTS));
	assign rd_addr = IW'(cnt_q - CW'(1));
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_addr] <= '{top_prio, spent_cycles, budget_cycles, rfu_factor,
				rfu_offset, starve_age};
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			loaded_q <= '0;
			seed_valid_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == ST_WALK);
			valid_s2 <= valid_s1 && ld_s1;
			case (state_q)
				ST_LOAD: begin
					if (wr_ok) begin
						loaded_q[wr_addr] <= 1'b1;
					end
					if (in_xfer && is_seed) begin
						seed_valid_q <= 1'b1;
					end
					if (in_xfer && last_record) begin
						state_q <= ST_WALK;
						cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if (cnt_q == CW'(MAX_PARTS)) begin
						state_q <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_FLUSH: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						loaded_q <= '0;
						seed_valid_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			crit_q[wr_addr] <= running_critical;
			active_q[wr_addr] <= holds_active;
		end
		if (in_xfer && is_seed) begin
			seed_rec_q <= '{top_prio, spent_cycles, budget_cycles, rfu_factor, rfu_offset,
				{CYC_W{1'b0}}};
			seed_part_q <= part_id;
			seed_crit_q <= running_critical;
		end
		seed_s1 <= (cnt_q == '0);
		idx_s1 <= rd_addr;
	end

	// read stage: margin check and rfu product
	always_comb begin
		rec_s1 = seed_s1 ? seed_rec_q : rd_q;
		ld_s1 = seed_s1 ? (seed_valid_q && seed_rec_q.prio != '0) : loaded_q[idx_s1];
		crit_s1 = seed_s1 ? seed_crit_q : crit_q[idx_s1];
		act_s1 = seed_s1 ? 1'b0 : active_q[idx_s1];
		need_s1 = {1'b0, rec_s1.used} + {1'b0, min_cycles_q};
		may_s1 = need_s1 <= {1'b0, rec_s1.budget};
		prod_s1 = CYC_W'(rec_s1.used[CYC_W-1:RFU_SHIFT] * rec_s1.factor);
	end

	always_ff @(posedge clk) begin
		seed_s2 <= seed_s1;
		idx_s2 <= idx_s1;
		may_s2 <= may_s1;
		crit_s2 <= crit_s1;
		active_s2 <= act_s1;
		zero_s2 <= (rec_s1.budget == '0);
		prio_s2 <= rec_s1.prio;
		prod_s2 <= prod_s1;
		offset_s2 <= rec_s1.offset;
		starve_s2 <= rec_s1.starve;
	end

	// rank stage
	assign run_s2 = may_s2 || crit_s2;
	always_comb begin
		cand.starve = starve_s2;
		cand.run = run_s2;
		cand.prio = prio_s2;
		cand.rfu = prod_s2 + offset_s2;
		cand.crit = crit_s2;
		cand.may = may_s2;
		cand.part = seed_s2 ? seed_part_q : PART_W'(idx_s2);
		rctl.init = (state_q == ST_LOAD) && in_xfer && last_record;
		rctl.seed = seed_s2;
		rctl.valid = valid_s2 && (seed_s2 || prio_s2 != '0);
	end

	pba_best u_best_prio (
		.clk     (clk),
		.arst_n  (arst_n),
		.prio_en (1'b1),
		.ctl     (rctl),
		.cand    (cand),
		.best    (best_p)
	);

	pba_best u_best_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.prio_en (1'b0),
		.ctl     (rctl),
		.cand    (cand),
		.best    (best_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= '0;
			runable_any_q <= 1'b0;
			sleep_any_q <= 1'b0;
		end else if (rctl.init) begin
			comp_q <= '0;
			runable_any_q <= 1'b0;
			sleep_any_q <= 1'b0;
		end else if (valid_s2 && !seed_s2) begin
			if ((prio_s2 != '0 && run_s2) || (active_s2 && may_s2)) begin
				comp_q[idx_s2] <= 1'b1;
			end
			if (prio_s2 != '0 && run_s2) begin
				runable_any_q <= 1'b1;
			end
			if (prio_s2 == '0 && !active_s2 && !zero_s2) begin
				sleep_any_q <= 1'b1;
			end
		end
	end

	always_comb begin
		prio_en = runable_any_q || (sleep_any_q && !ratio_q);
		best = prio_en ? best_p : best_r;
		for (int j = 0; j < MAX_PARTS; j++) begin
			comp_x[j] = comp_q[j] && (PART_W'(j) != best.c.part);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			found_q <= best.have;
			part_q <= best.have ? best.c.part : '0;
			prio_q <= best.have ? best.c.prio : '0;
			bill_q <= best.have && best.c.crit && !best.c.may && (comp_x != '0);
			mode_q <= runable_any_q ? MODE_UNDERLOAD :
				(sleep_any_q ? MODE_FREETIME : MODE_LIMIT);
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign chosen_part = part_q;
	assign chosen_prio = prio_q;
	assign bill_critical = bill_q;
	assign sched_mode = mode_q;

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> chosen_part == '0 && chosen_prio == '0 && !bill_critical)
		else $error("idle decision carries a winner");
	a_found_prio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> chosen_prio != '0)
		else $error("winner with priority zero");
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sched_mode != 2'd3)
		else $error("bad mode");
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !valid_s1 && !valid_s2)
		else $error("result taken before pipeline drained");
	a_no_load_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !in_ready)
		else $error("transfer accepted during walk");

endmodule
